### sv/tde_pkg.sv
// shared types and constants for the trace decay time estimator
package tde_pkg;

  localparam int MAX_SAMPLES = 4096;
  localparam int MANT_FRAC   = 62;
  localparam int LOG_FRAC    = 56;
  localparam int DIV_BITS    = 73;

  localparam logic [62:0] LOG2E_Q62    = 63'h5C551D94AE0BF85E;
  localparam logic [72:0] DIV_NUM      = {LOG2E_Q62, 10'b0};
  localparam logic [46:0] MAG_MAX      = 47'h7FFFFFFFFFFF;
  localparam logic [12:0] TRIM_RECIP   = 13'd6554;
  localparam logic [19:0] PERIOD_RESET = 20'd4000;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_NONPOS = 2'd2,
    ST_SAT    = 2'd3
  } tau_status_t;

  typedef enum logic [4:0] {
    S_LOAD, S_SRCH_INIT, S_SRCH_RD, S_SRCH_CMP, S_TRIM,
    S_SUM_A, S_SUM_B, S_SUM_C, S_SUM_D, S_CLASS, S_NORM, S_MANT,
    S_SQ_LL, S_SQ_HL, S_SQ_HH, S_SQ_FIN, S_DIV, S_MAG, S_PS, S_OUT
  } state_t;

  typedef enum logic [4:0] {
    CMD_LOAD, CMD_SRCH_INIT, CMD_SRCH_RD, CMD_SRCH_CMP, CMD_TRIM,
    CMD_SUM_A, CMD_SUM_B, CMD_SUM_C, CMD_SUM_D, CMD_CLASS, CMD_NORM, CMD_MANT,
    CMD_SQ_LL, CMD_SQ_HL, CMD_SQ_HH, CMD_SQ_FIN, CMD_DIV, CMD_MAG, CMD_PS, CMD_OUT
  } cmd_t;

  typedef struct packed {
    logic srch_done;
    logic sum_done;
    logic special;
    logic norm_done;
    logic mant_last;
    logic sq_last;
    logic div_last;
    logic out_free;
  } dp_status_t;

endpackage

### sv/trace_decay_time_estimator.sv
// Samples load at one item per cycle while in the load state; a non-last or piled-up
// item keeps the block there. After the last item the search reads, then compares, each
// sample past the peak; each window sample takes four sum steps (weight product, weight,
// sum1, sum2), then normalize, 62-bit mantissa divide, log squaring and 73-bit divide.
// Sync active-high reset clears control, trace counters and sets period to 4000 ps;
// the trace store is not cleared, no clearing pass.
module trace_decay_time_estimator import tde_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [15:0]        sample,
  input  logic               last,
  input  logic               piled_up,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         status,
  output logic signed [47:0] tau_ticks,
  output logic signed [47:0] tau_ps,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [19:0]        cfg_data
);

  cmd_t       cmd;
  dp_status_t stat;

  assign cfg_ready = 1'b1;

  tde_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .last     (last),
    .piled_up (piled_up),
    .stat     (stat),
    .cmd      (cmd),
    .in_ready (in_ready)
  );

  tde_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_valid  (in_valid),
    .sample    (sample),
    .last      (last),
    .piled_up  (piled_up),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .status    (status),
    .tau_ticks (tau_ticks),
    .tau_ps    (tau_ps)
  );

endmodule

### sv/tde_datapath.sv
// trace store, search, weighted sums, log and divide datapath
module tde_datapath import tde_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  output dp_status_t         stat,
  input  logic               in_valid,
  input  logic [15:0]        sample,
  input  logic               last,
  input  logic               piled_up,
  input  logic               cfg_valid,
  input  logic [19:0]        cfg_data,
  input  logic               out_ready,
  output logic               out_valid,
  output logic [1:0]         status,
  output logic signed [47:0] tau_ticks,
  output logic signed [47:0] tau_ps
);

  logic [15:0] mem [MAX_SAMPLES];
  logic [15:0] rd_data;
  logic [11:0] rd_addr;
  logic        mem_we;
  logic        sum_phase;

  logic [12:0] count;
  logic [15:0] peak_val;
  logic [11:0] peak_idx;
  logic [19:0] period;

  logic [12:0] idx;
  logic [11:0] mn_idx;
  logic [15:0] min_val;
  logic [11:0] n;
  logic [11:0] start;
  logic [23:0] p1;
  logic signed [38:0] w;
  logic signed [38:0] wprev;
  logic signed [63:0] sum1;
  logic signed [63:0] sum2;
  logic [63:0] big;
  logic [63:0] den;
  logic [63:0] rem;
  logic [5:0]  k;
  logic        neg;
  logic [63:0] m;
  logic [127:0] acc;
  logic [55:0] frac;
  logic [61:0] lg;
  logic [72:0] quo;
  logic [46:0] mag;
  logic        tsat;
  tau_status_t res_status;
  logic [47:0] res_ticks;
  logic [47:0] res_ps;

  // combinational terms
  logic [12:0] j;
  logic [11:0] j12;
  logic [11:0] nmj;
  logic [23:0] p1_next;
  logic signed [13:0] dd;
  logic signed [38:0] w_next;
  logic signed [16:0] xs;
  logic signed [55:0] pc;
  logic signed [55:0] pd;
  logic [11:0] size;
  logic [24:0] tprod;
  logic [8:0]  trim;
  logic [11:0] n_next;
  logic [11:0] start_next;
  logic [63:0] a_mag;
  logic [63:0] b_mag;
  logic        s1z;
  logic        s2z;
  logic        sdiff;
  logic        eq;
  logic        a_lt_b;
  logic [63:0] den2;
  logic        norm_ok;
  logic [63:0] rem2;
  logic        mbit;
  logic [63:0] rem_m;
  logic [63:0] m_shift;
  logic [31:0] mop_a;
  logic [31:0] mop_b;
  logic [63:0] mprod;
  logic [63:0] sq;
  logic        dbit;
  logic [63:0] rem_d;
  logic        qbit;
  logic [63:0] rem_dn;
  logic        tsat_next;
  logic [46:0] mag_next;
  logic [66:0] pprod;
  logic        psat;
  logic [46:0] pmag;

  assign mem_we    = (cmd == CMD_LOAD) && in_valid && !count[12];
  // the window sample stays addressed through all four sum steps
  assign sum_phase = (cmd == CMD_SUM_A) || (cmd == CMD_SUM_B) ||
                     (cmd == CMD_SUM_C) || (cmd == CMD_SUM_D);
  assign rd_addr   = sum_phase ? (start + idx[11:0]) : idx[11:0];

  always_ff @(posedge clk) begin
    if (mem_we) mem[count[11:0]] <= sample;
    rd_data <= mem[rd_addr];
  end

  always_comb begin
    j          = idx + 13'd1;
    j12        = j[11:0];
    nmj        = n - j12;
    p1_next    = {12'b0, j12} * {12'b0, nmj};
    dd         = $signed({2'b00, n}) - $signed({1'b0, j12, 1'b0});
    w_next     = $signed({1'b0, p1}) * dd;
    xs         = $signed({1'b0, rd_data});
    pc         = xs * w;
    pd         = xs * wprev;
    size       = mn_idx - peak_idx;
    tprod      = {13'b0, size} * {12'b0, TRIM_RECIP};
    trim       = tprod[24:16];
    n_next     = size - {2'b00, trim, 1'b0};
    start_next = peak_idx + {3'b000, trim};

    a_mag  = sum1[63] ? (~sum1 + 64'd1) : sum1;
    b_mag  = sum2[63] ? (~sum2 + 64'd1) : sum2;
    s1z    = (sum1 == 64'sd0);
    s2z    = (sum2 == 64'sd0);
    sdiff  = sum1[63] != sum2[63];
    eq     = a_mag == b_mag;
    a_lt_b = a_mag < b_mag;

    den2    = {den[62:0], 1'b0};
    norm_ok = den2 <= big;

    rem2    = {rem[62:0], 1'b0};
    mbit    = rem2 >= den;
    rem_m   = mbit ? (rem2 - den) : rem2;
    m_shift = {m[62:0], mbit};

    // one 32x32 partial product per squaring step
    case (cmd)
      CMD_SQ_LL: begin mop_a = m[31:0];          mop_b = m[31:0];          end
      CMD_SQ_HL: begin mop_a = {1'b0, m[62:32]}; mop_b = m[31:0];          end
      default:   begin mop_a = {1'b0, m[62:32]}; mop_b = {1'b0, m[62:32]}; end
    endcase
    mprod = {32'b0, mop_a} * {32'b0, mop_b};
    sq    = acc[125:62];

    dbit   = DIV_NUM[7'(DIV_BITS - 1) - idx[6:0]];
    rem_d  = {rem[62:0], dbit};
    qbit   = rem_d >= {2'b00, lg};
    rem_dn = qbit ? (rem_d - {2'b00, lg}) : rem_d;

    // a zero log divides to all ones and saturates here as well
    tsat_next = quo > {26'b0, MAG_MAX};
    mag_next  = tsat_next ? MAG_MAX : quo[46:0];
    pprod     = {20'b0, mag} * {47'b0, period};
    psat      = tsat || (pprod > {20'b0, MAG_MAX});
    pmag      = psat ? MAG_MAX : pprod[46:0];
  end

  always_comb begin
    stat.srch_done = idx >= count;
    stat.sum_done  = idx == {1'b0, n};
    stat.special   = s2z || s1z || sdiff || eq;
    stat.norm_done = !norm_ok;
    stat.mant_last = idx == 13'(MANT_FRAC - 1);
    stat.sq_last   = idx == 13'(LOG_FRAC - 1);
    stat.div_last  = idx == 13'(DIV_BITS - 1);
    stat.out_free  = !out_valid || out_ready;
  end

  // control state: trace bookkeeping, output valid, period register
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      peak_val  <= '0;
      peak_idx  <= '0;
      out_valid <= 1'b0;
      period    <= PERIOD_RESET;
    end else begin
      if (cfg_valid) period <= cfg_data;
      if ((cmd == CMD_OUT) && stat.out_free) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      case (cmd)
        CMD_LOAD: begin
          if (in_valid) begin
            if (last && piled_up) begin
              count    <= '0;
              peak_val <= '0;
              peak_idx <= '0;
            end else if (!count[12]) begin
              if (count == 13'd0 || sample > peak_val) begin
                peak_val <= sample;
                peak_idx <= count[11:0];
              end
              count <= count + 13'd1;
            end
          end
        end
        CMD_OUT: begin
          if (stat.out_free) begin
            count     <= '0;
            peak_val  <= '0;
            peak_idx  <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd)
      CMD_SRCH_INIT: begin
        idx     <= {1'b0, peak_idx} + 13'd1;
        mn_idx  <= peak_idx;
        min_val <= peak_val;
      end
      CMD_SRCH_CMP: begin
        if (rd_data < min_val) begin
          min_val <= rd_data;
          mn_idx  <= idx[11:0];
        end
        idx <= idx + 13'd1;
      end
      CMD_TRIM: begin
        n     <= n_next;
        start <= start_next;
        idx   <= '0;
        sum1  <= '0;
        sum2  <= '0;
        wprev <= '0;
      end
      CMD_SUM_A: p1 <= p1_next;
      CMD_SUM_B: w <= w_next;
      CMD_SUM_C: sum1 <= sum1 + {{8{pc[55]}}, pc};
      CMD_SUM_D: begin
        sum2  <= sum2 + {{8{pd[55]}}, pd};
        wprev <= w;
        idx   <= idx + 13'd1;
      end
      CMD_CLASS: begin
        big <= a_lt_b ? b_mag : a_mag;
        den <= a_lt_b ? a_mag : b_mag;
        k   <= '0;
        neg <= a_lt_b;
        if (s2z) begin
          res_status <= ST_EMPTY;
          res_ticks  <= '0;
          res_ps     <= '0;
        end else if (s1z || sdiff) begin
          res_status <= ST_NONPOS;
          res_ticks  <= '0;
          res_ps     <= '0;
        end else begin
          res_status <= ST_SAT;
          res_ticks  <= {1'b0, MAG_MAX};
          res_ps     <= {1'b0, MAG_MAX};
        end
      end
      CMD_NORM: begin
        if (norm_ok) begin
          den <= den2;
          k   <= k + 6'd1;
        end else begin
          rem <= big - den;
          m   <= '0;
          idx <= '0;
        end
      end
      CMD_MANT: begin
        rem <= rem_m;
        if (stat.mant_last) begin
          m    <= m_shift | (64'd1 << MANT_FRAC);
          frac <= '0;
          idx  <= '0;
        end else begin
          m   <= m_shift;
          idx <= idx + 13'd1;
        end
      end
      CMD_SQ_LL: acc <= {64'b0, mprod};
      CMD_SQ_HL: acc <= acc + {31'b0, mprod, 33'b0};
      CMD_SQ_HH: acc <= acc + {mprod, 64'b0};
      CMD_SQ_FIN: begin
        frac <= {frac[54:0], sq[63]};
        m    <= sq[63] ? {1'b0, sq[63:1]} : sq;
        if (stat.sq_last) begin
          lg  <= {k, frac[54:0], sq[63]};
          idx <= '0;
          rem <= '0;
          quo <= '0;
        end else begin
          idx <= idx + 13'd1;
        end
      end
      CMD_DIV: begin
        rem <= rem_dn;
        quo <= {quo[71:0], qbit};
        idx <= idx + 13'd1;
      end
      CMD_MAG: begin
        mag  <= mag_next;
        tsat <= tsat_next;
      end
      CMD_PS: begin
        res_status <= psat ? ST_SAT : ST_OK;
        res_ticks  <= neg ? (48'd0 - {1'b0, mag})  : {1'b0, mag};
        res_ps     <= neg ? (48'd0 - {1'b0, pmag}) : {1'b0, pmag};
      end
      CMD_OUT: begin
        if (stat.out_free) begin
          status    <= res_status;
          tau_ticks <= res_ticks;
          tau_ps    <= res_ps;
        end
      end
      default: ;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= 13'(MAX_SAMPLES))
    else $error("sample count past store depth");
  a_mant_rem: assert property (@(posedge clk) disable iff (rst)
    cmd == CMD_MANT |-> rem < den)
    else $error("mantissa remainder not below divisor");
  a_log_norm: assert property (@(posedge clk) disable iff (rst)
    cmd == CMD_SQ_LL |-> m[63:62] == 2'b01)
    else $error("log mantissa left [1,2)");
  a_trim_order: assert property (@(posedge clk) disable iff (rst)
    cmd == CMD_TRIM |-> mn_idx >= peak_idx)
    else $error("minimum found before peak");
`endif

endmodule

### sv/tde_ctrl.sv
// sequencing state machine for the trace decay time estimator
module tde_ctrl import tde_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       last,
  input  logic       piled_up,
  input  dp_status_t stat,
  output cmd_t       cmd,
  output logic       in_ready
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_LOAD;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_LOAD:      if (in_valid && last && !piled_up) state_next = S_SRCH_INIT;
      S_SRCH_INIT: state_next = S_SRCH_RD;
      S_SRCH_RD:   state_next = stat.srch_done ? S_TRIM : S_SRCH_CMP;
      S_SRCH_CMP:  state_next = S_SRCH_RD;
      S_TRIM:      state_next = S_SUM_A;
      S_SUM_A:     state_next = stat.sum_done ? S_CLASS : S_SUM_B;
      S_SUM_B:     state_next = S_SUM_C;
      S_SUM_C:     state_next = S_SUM_D;
      S_SUM_D:     state_next = S_SUM_A;
      S_CLASS:     state_next = stat.special ? S_OUT : S_NORM;
      S_NORM:      if (stat.norm_done) state_next = S_MANT;
      S_MANT:      if (stat.mant_last) state_next = S_SQ_LL;
      S_SQ_LL:     state_next = S_SQ_HL;
      S_SQ_HL:     state_next = S_SQ_HH;
      S_SQ_HH:     state_next = S_SQ_FIN;
      S_SQ_FIN:    state_next = stat.sq_last ? S_DIV : S_SQ_LL;
      S_DIV:       if (stat.div_last) state_next = S_MAG;
      S_MAG:       state_next = S_PS;
      S_PS:        state_next = S_OUT;
      S_OUT:       if (stat.out_free) state_next = S_LOAD;
      default:     state_next = S_LOAD;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    case (state)
      S_LOAD:      begin cmd = CMD_LOAD; in_ready = 1'b1; end
      S_SRCH_INIT: cmd = CMD_SRCH_INIT;
      S_SRCH_RD:   cmd = CMD_SRCH_RD;
      S_SRCH_CMP:  cmd = CMD_SRCH_CMP;
      S_TRIM:      cmd = CMD_TRIM;
      S_SUM_A:     cmd = CMD_SUM_A;
      S_SUM_B:     cmd = CMD_SUM_B;
      S_SUM_C:     cmd = CMD_SUM_C;
      S_SUM_D:     cmd = CMD_SUM_D;
      S_CLASS:     cmd = CMD_CLASS;
      S_NORM:      cmd = CMD_NORM;
      S_MANT:      cmd = CMD_MANT;
      S_SQ_LL:     cmd = CMD_SQ_LL;
      S_SQ_HL:     cmd = CMD_SQ_HL;
      S_SQ_HH:     cmd = CMD_SQ_HH;
      S_SQ_FIN:    cmd = CMD_SQ_FIN;
      S_DIV:       cmd = CMD_DIV;
      S_MAG:       cmd = CMD_MAG;
      S_PS:        cmd = CMD_PS;
      S_OUT:       cmd = CMD_OUT;
      default:     cmd = CMD_SRCH_RD;
    endcase
  end

endmodule

### dv/tb_top.sv
// self-checking testbench for trace_decay_time_estimator
`timescale 1ns / 1ps

module tb_top;
  import tde_pkg::*;

  typedef struct {
    logic [15:0] sample;
    logic        last;
    logic        piled_up;
  } trace_item_t;

  typedef struct {
    tau_status_t st;
    logic [47:0] ticks;
    logic [47:0] ps;
  } tau_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0, in_ready;
  logic [15:0] sample = '0;
  logic last = 1'b0, piled_up = 1'b0;
  logic out_valid, out_ready = 1'b0;
  logic [1:0] status;
  logic signed [47:0] tau_ticks, tau_ps;
  logic cfg_valid = 1'b0, cfg_ready;
  logic [19:0] cfg_data = '0;

  trace_item_t pending_items[$];
  tau_result_t tau_expected[$];
  bit failed = 0;
  bit no_idle = 0;
  int send_gap = 0, stall_len = 0;

  // predictor state
  logic [15:0] trace_mem [MAX_SAMPLES];
  int unsigned trace_len = 0, peak_val = 0, peak_idx = 0;
  logic [19:0] period_ps = PERIOD_RESET;

  trace_decay_time_estimator i_dut (
    .clk, .rst, .in_valid, .in_ready, .sample, .last, .piled_up,
    .out_valid, .out_ready, .status, .tau_ticks, .tau_ps,
    .cfg_valid, .cfg_ready, .cfg_data
  );

  always #6 clk = ~clk;

  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 19);
    if (no_idle || r < 12) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  function automatic longint weight(longint j, longint n);
    return j * (n - j) * (n - 2 * j);
  endfunction

  function automatic int msb_pos(logic [63:0] v);
    int p;
    p = -1;
    for (int b = 0; b < 64; b++) if (v[b]) p = b;
    return p;
  endfunction

  function automatic void estimate_tau(trace_item_t it);
    int unsigned mn, span, trim, n, start;
    longint sum1, sum2;
    logic [63:0] a, b, big, sml, den, m, frac, lg;
    logic [127:0] prod, quo;
    logic [47:0] mag, pmag;
    int k;
    bit neg, tsat, psat;
    tau_result_t res;
    sum1 = 0; sum2 = 0; frac = 0; mag = 0; pmag = 0; tsat = 0; psat = 0; neg = 0;
    if (trace_len < MAX_SAMPLES) begin
      trace_mem[trace_len] = it.sample;
      if (trace_len == 0 || it.sample > peak_val) begin
        peak_val = it.sample;
        peak_idx = trace_len;
      end
      trace_len++;
    end
    if (!it.last) return;
    if (it.piled_up) begin
      trace_len = 0; peak_val = 0; peak_idx = 0;
      return;
    end
    mn = peak_idx;
    for (int unsigned i = peak_idx + 1; i < trace_len; i++)
      if (trace_mem[i] < trace_mem[mn]) mn = i;
    span = mn - peak_idx;
    trim = span / 10;
    n = span - 2 * trim;
    start = peak_idx + trim;
    for (int unsigned i = 0; i < n; i++) begin
      sum1 += longint'(trace_mem[(start + i) % MAX_SAMPLES]) * weight(i + 1, n);
      sum2 += longint'(trace_mem[(start + i) % MAX_SAMPLES]) * weight(i, n);
    end
    trace_len = 0; peak_val = 0; peak_idx = 0;
    if (sum2 == 0) begin
      res.st = ST_EMPTY;
    end else if (sum1 == 0 || ((sum1 < 0) != (sum2 < 0))) begin
      res.st = ST_NONPOS;
    end else begin
      a = sum1 < 0 ? -sum1 : sum1;
      b = sum2 < 0 ? -sum2 : sum2;
      neg = a < b;
      big = neg ? b : a;
      sml = neg ? a : b;
      if (big == sml) begin
        tsat = 1;
        neg = 0;
      end else begin
        k = msb_pos(big) - msb_pos(sml);
        if (big < (sml << k)) k--;
        den = sml << k;
        m = (128'(big) << MANT_FRAC) / den;
        for (int f = 0; f < LOG_FRAC; f++) begin
          prod = 128'(m) * 128'(m);
          m = prod >> MANT_FRAC;
          frac = frac << 1;
          if (m[63]) begin
            frac[0] = 1'b1;
            m = m >> 1;
          end
        end
        lg = (64'(k) << LOG_FRAC) + frac;
        if (lg == 0) tsat = 1;
        else begin
          quo = 128'(DIV_NUM) / lg;
          if (quo > MAG_MAX) tsat = 1;
          else mag = quo[47:0];
        end
      end
      if (tsat) begin
        mag = MAG_MAX; pmag = MAG_MAX; psat = 1;
      end else if (period_ps != 0 && mag > MAG_MAX / period_ps) begin
        pmag = MAG_MAX; psat = 1;
      end else begin
        pmag = mag * period_ps;
      end
      res.st = (tsat || psat) ? ST_SAT : ST_OK;
      if (neg) begin
        mag = -mag;
        pmag = -pmag;
      end
    end
    res.ticks = mag;
    res.ps = pmag;
    tau_expected.push_back(res);
  endfunction

  // input driver
  always @(posedge clk) begin
    trace_item_t it;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) estimate_tau('{sample, last, piled_up});
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          it = pending_items.pop_front();
          sample <= it.sample;
          last <= it.last;
          piled_up <= it.piled_up;
          in_valid <= 1'b1;
          send_gap <= rand_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    tau_result_t e;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (tau_expected.size() == 0) begin
          $error("unexpected result status=%0d", status);
          failed = 1;
        end else begin
          e = tau_expected.pop_front();
          if (status !== e.st) begin
            $error("status: expected %0d, actual %0d", e.st, status);
            failed = 1;
          end
          if (tau_ticks !== e.ticks) begin
            $error("tau_ticks: expected %h, actual %h", e.ticks, tau_ticks);
            failed = 1;
          end
          if (tau_ps !== e.ps) begin
            $error("tau_ps: expected %h, actual %h", e.ps, tau_ps);
            failed = 1;
          end
        end
      end
      if (stall_len > 0) begin
        stall_len <= stall_len - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        stall_len <= rand_gap();
      end
    end
  end

  task automatic push_sample(int s, bit lst = 0, bit pu = 0);
    pending_items.push_back('{16'(s), lst, pu});
  endtask

  // decaying pulse after a short baseline, with optional noise
  task automatic push_decay(int len, real amp, real tc, int base, int noise, bit pu);
    int pre, v;
    pre = $urandom_range(0, 3);
    for (int i = 0; i < len; i++) begin
      if (i < pre) v = base;
      else v = base + int'(amp * $exp(-(i - pre) / tc));
      if (noise > 0) v += $urandom_range(0, 2 * noise) - noise;
      if (v < 0) v = 0;
      if (v > 65535) v = 65535;
      push_sample(v, i == len - 1, pu);
    end
  endtask

  task automatic write_period(logic [19:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    period_ps = v;
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (pending_items.size() > 0 || in_valid || tau_expected.size() > 0)
      @(posedge clk);
    // a piled-up trace may still be in flight with nothing expected
    repeat (3000) @(posedge clk);
  endtask

  task automatic random_traces(int n_items);
    int sent, len, kind, base;
    sent = 0;
    while (sent < n_items) begin
      len = ($urandom_range(0, 15) == 0) ? $urandom_range(40, 120) : $urandom_range(2, 30);
      kind = $urandom_range(0, 9);
      base = $urandom_range(0, 2000);
      if (kind < 7)
        push_decay(len, $urandom_range(100, 65535 - base), $urandom_range(1, 400) / 10.0,
                   base, $urandom_range(0, 1) ? 0 : $urandom_range(1, 200),
                   $urandom_range(0, 9) == 0);
      else if (kind < 9)
        for (int i = 0; i < len; i++)
          push_sample($urandom, i == len - 1, $urandom_range(0, 5) == 0);
      else
        // slow decay drives the ratio near one
        push_decay(len, $urandom_range(10000, 60000), $urandom_range(1000, 100000), 0, 0, 0);
      sent += len;
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: single sample, pile-up, extremes, flat, rising, noisy
    push_sample(16'hFFFF, 1);
    push_sample(0, 1);
    push_sample(100); push_sample(200, 1, 1);
    push_sample(65535); push_sample(32768); push_sample(16384); push_sample(8192);
    push_sample(4096); push_sample(0, 1);
    for (int i = 0; i < 5; i++) push_sample(777, i == 4);
    for (int i = 0; i < 5; i++) push_sample(i * 1000, i == 4);
    push_sample(1000); push_sample(10); push_sample(900); push_sample(20);
    push_sample(5000); push_sample(0, 1);
    drain();

    random_traces(400);
    drain();

    write_period(20'd1);
    no_idle = 1;
    random_traces(300);
    drain();
    no_idle = 0;

    write_period(20'd1000000);
    random_traces(300);
    drain();

    write_period(20'($urandom_range(1, 1000000)));
    random_traces(350);
    drain();

    write_period(20'd4000);
    random_traces(300);
    drain();

    if (tau_expected.size() != 0) failed = 1;
    if (!failed) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  initial begin
    #20ms;
    $display("Verification failed");
    $finish;
  end

endmodule

### sim.f
sv/tde_pkg.sv
sv/tde_datapath.sv
sv/tde_ctrl.sv
sv/trace_decay_time_estimator.sv
dv/tb_top.sv
